// ===== hw/rtl/esd_pkg.sv =====
// Shared types and constants for the escape sequence decoder.
`timescale 1ns / 1ps

package esd_pkg;

	// Decoder mode register encoding.
	typedef enum logic [2:0] {
		MODE_NORMAL = 3'd0,
		MODE_ESCAPE = 3'd1,
		MODE_CODE0  = 3'd2,
		MODE_CODE1  = 3'd3,
		MODE_CODE2  = 3'd4
	} mode_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_UNKNOWN = 2'd1,
		ST_LONE    = 2'd2,
		ST_SHORT   = 2'd3
	} status_t;

	// Character constants.
	localparam logic [7:0] CH_BACKSLASH = 8'd92;
	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_CODE      = 8'd99;
	localparam logic [7:0] DIGIT_BASE   = 8'd48;
	localparam logic [7:0] WEIGHT_HUNDREDS = 8'd100;
	localparam logic [7:0] WEIGHT_TENS     = 8'd10;

	// One input character.
	typedef struct packed {
		logic [7:0] in_char;
		logic       in_last;
	} in_item_t;

	// One decoded result.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		status_t    status;
		logic       string_end;
	} out_item_t;

	// Everything the decode step produces for one character.
	typedef struct packed {
		mode_t      next_mode;
		logic [7:0] next_acc;
		logic       emit;
		out_item_t  result;
	} dec_t;

endpackage

// ===== hw/rtl/esd_if.sv =====
// Valid/ready channel interfaces for the input characters and decoded results.
`timescale 1ns / 1ps

interface esd_in_if;
	import esd_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface esd_out_if;
	import esd_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ===== hw/rtl/esd_decode.sv =====
// Combinational decode of one character against the current mode and accumulator.
`timescale 1ns / 1ps

module esd_decode (
	input  esd_pkg::in_item_t item,
	input  esd_pkg::mode_t    mode,
	input  logic [7:0]        acc,
	output esd_pkg::dec_t     dec
);
	import esd_pkg::*;

	logic [7:0] digit;
	logic       simple_hit;
	logic [7:0] simple_byte;

	assign digit = item.in_char - DIGIT_BASE;

	// Map of the single-letter escapes to their control bytes.
	always_comb begin
		simple_hit  = 1'b1;
		simple_byte = 8'd0;
		case (item.in_char)
			8'd110: simple_byte = 8'd10;  // n
			8'd92:  simple_byte = 8'd92;  // backslash
			8'd98:  simple_byte = 8'd8;   // b
			8'd101: simple_byte = 8'd27;  // e
			8'd102: simple_byte = 8'd12;  // f
			8'd114: simple_byte = 8'd13;  // r
			8'd116: simple_byte = 8'd9;   // t
			8'd118: simple_byte = 8'd11;  // v
			8'd97:  simple_byte = 8'd7;   // a
			default: simple_hit = 1'b0;
		endcase
	end

	// Mode transition and result formation.
	always_comb begin
		logic       has;
		logic [7:0] byte_val;
		status_t    st;
		logic       emit;
		mode_t      nmode;
		logic [7:0] nacc;

		has      = 1'b0;
		byte_val = 8'd0;
		st       = ST_OK;
		emit     = 1'b0;
		nmode    = MODE_NORMAL;
		nacc     = acc;

		case (mode)
			MODE_ESCAPE: begin
				if (simple_hit) begin
					has      = 1'b1;
					byte_val = simple_byte;
					emit     = 1'b1;
				end else if (item.in_char == CH_CODE) begin
					if (item.in_last) st = ST_SHORT;
					nmode = MODE_CODE0;
				end else begin
					st   = ST_UNKNOWN;
					emit = 1'b1;
				end
			end
			MODE_CODE0: begin
				nacc  = 8'(digit * WEIGHT_HUNDREDS);
				if (item.in_last) st = ST_SHORT;
				nmode = MODE_CODE1;
			end
			MODE_CODE1: begin
				nacc  = 8'(acc + 8'(digit * WEIGHT_TENS));
				if (item.in_last) st = ST_SHORT;
				nmode = MODE_CODE2;
			end
			MODE_CODE2: begin
				byte_val = 8'(acc + digit);
				has      = 1'b1;
				emit     = 1'b1;
				nacc     = 8'd0;
			end
			default: begin
				if (item.in_char == CH_BACKSLASH) begin
					if (item.in_last) st = ST_LONE;
					nmode = MODE_ESCAPE;
				end else if (item.in_char != CH_NEWLINE) begin
					byte_val = item.in_char;
					has      = 1'b1;
					emit     = 1'b1;
				end
			end
		endcase

		// The final character always produces a result and restarts the decoder.
		if (item.in_last) begin
			emit  = 1'b1;
			nmode = MODE_NORMAL;
			nacc  = 8'd0;
		end

		dec.next_mode           = nmode;
		dec.next_acc            = nacc;
		dec.emit                = emit;
		dec.result.out_byte     = has ? byte_val : 8'd0;
		dec.result.has_byte     = has;
		dec.result.status       = st;
		dec.result.string_end   = item.in_last;
	end

endmodule

// ===== hw/rtl/esd_out_reg.sv =====
// Result register that holds a decoded result until the receiver takes it.
`timescale 1ns / 1ps

module esd_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  esd_pkg::out_item_t load_data,
	output logic               space,
	esd_out_if.source          res
);
	import esd_pkg::*;

	logic      valid_q;
	out_item_t data_q;

	// A new result may be loaded when the register is empty or being drained.
	assign space = !valid_q || res.ready;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (space && load) begin
			data_q <= load_data;
		end
	end

	assign res.valid   = valid_q;
	assign res.payload = data_q;

endmodule

// ===== hw/rtl/escape_sequence_decoder_top.sv =====
// Top level of the escape sequence decoder: input register, mode state and result register.
// Usage:
// The text channel carries one character of an escaped string per transfer, with
// in_last set on the final character. The decoded channel carries results: a byte
// (has_byte set), a status code, and string_end on the result of the final character.
// Characters inside an unfinished escape and dropped newlines give no transfer.
// A result passes two registers: the input register, where the character is decoded
// against the mode register, and then the result register.
// Throughput is one character per cycle while the receiver takes results; the mode
// and accumulator update with each character that moves on, so consecutive characters
// follow each other without gaps.
// When the receiver stalls, the result register holds its result and the input
// register holds one more character; text.ready then drops until the receiver takes
// a result. A held character that produces no result still moves on during a stall.
// Reset clears both valid flags, sets normal character mode and clears the
// code accumulator; no transfer is in flight afterwards.
`timescale 1ns / 1ps

module escape_sequence_decoder_top (
	input  logic       clk,
	input  logic       arst_n,
	esd_in_if.sink     text,
	esd_out_if.source  decoded
);
	import esd_pkg::*;

	logic       valid_s1;
	in_item_t   item_s1;
	mode_t      mode_q;
	logic [7:0] acc_q;
	dec_t       dec;
	logic       out_space;
	logic       advance;

	// The held character moves on when it emits nothing or the result register has room.
	assign advance    = valid_s1 && (!dec.emit || out_space);
	assign text.ready = !valid_s1 || advance;

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			item_s1 <= text.payload;
		end
	end

	// Decoder state updates once per character that moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			acc_q  <= 8'd0;
		end else if (advance) begin
			mode_q <= dec.next_mode;
			acc_q  <= dec.next_acc;
		end
	end

	esd_decode u_decode (
		.item (item_s1),
		.mode (mode_q),
		.acc  (acc_q),
		.dec  (dec)
	);

	esd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && dec.emit),
		.load_data (dec.result),
		.space     (out_space),
		.res       (decoded)
	);

	// A finished string always leaves the decoder in normal mode with a clear accumulator.
	a_end_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.in_last |=> mode_q == MODE_NORMAL && acc_q == 8'd0)
		else $error("decoder state not restarted after final character");

	// A held character that is blocked must stay in the input register.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input register changed while blocked");

	// End-of-string errors come only on the final result and carry no byte.
	a_end_errors: assert property (@(posedge clk) disable iff (!arst_n)
		decoded.valid && (decoded.payload.status == ST_LONE ||
		decoded.payload.status == ST_SHORT)
		|-> decoded.payload.string_end && !decoded.payload.has_byte)
		else $error("end-of-string error on a non-final result");

	// A result without a byte carries a zero byte field.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		decoded.valid && !decoded.payload.has_byte |-> decoded.payload.out_byte == 8'd0)
		else $error("nonzero byte on a result without a byte");

endmodule

// ===== tb/esd_decode_check.sv =====
// Checker for the escape sequence decoder: watches both channels, predicts and compares.
`timescale 1ns / 1ps

module esd_decode_check
	import esd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	esd_in_if    text,
	esd_out_if   decoded,
	output int   errors,
	output int   outstanding,
	output int   chars_seen,
	output int   strings_seen,
	output int   bytes_seen,
	output int   warnings_seen,
	output int   truncations_seen
);

	// Decoder state as predicted from the accepted characters.
	mode_t      dec_mode;
	logic [7:0] code_sum;
	out_item_t  awaited_results[$];

	initial begin
		errors = 0;
		outstanding = 0;
		chars_seen = 0;
		strings_seen = 0;
		bytes_seen = 0;
		warnings_seen = 0;
		truncations_seen = 0;
	end

	// Advances the predicted state by one character and queues the result it causes.
	task automatic decode_char(input in_item_t it);
		logic [7:0] digit;
		logic       emit;
		out_item_t  res;
		digit = it.in_char - DIGIT_BASE;
		emit = 1'b0;
		res = '0;
		case (dec_mode)
		MODE_ESCAPE: begin
			emit = 1'b1;
			res.has_byte = 1'b1;
			dec_mode = MODE_NORMAL;
			case (it.in_char)
			"n": res.out_byte = CH_NEWLINE;
			CH_BACKSLASH: res.out_byte = CH_BACKSLASH;
			"b": res.out_byte = 8'd8;
			"e": res.out_byte = 8'd27;
			"f": res.out_byte = 8'd12;
			"r": res.out_byte = 8'd13;
			"t": res.out_byte = 8'd9;
			"v": res.out_byte = 8'd11;
			"a": res.out_byte = 8'd7;
			CH_CODE: begin
				emit = 1'b0;
				res.has_byte = 1'b0;
				if (it.in_last)
					res.status = ST_SHORT;
				dec_mode = MODE_CODE0;
			end
			default: begin
				res.has_byte = 1'b0;
				res.status = ST_UNKNOWN;
			end
			endcase
		end
		MODE_CODE0: begin
			code_sum = digit * WEIGHT_HUNDREDS;
			if (it.in_last)
				res.status = ST_SHORT;
			dec_mode = MODE_CODE1;
		end
		MODE_CODE1: begin
			code_sum = code_sum + digit * WEIGHT_TENS;
			if (it.in_last)
				res.status = ST_SHORT;
			dec_mode = MODE_CODE2;
		end
		MODE_CODE2: begin
			res.out_byte = code_sum + digit;
			res.has_byte = 1'b1;
			emit = 1'b1;
			code_sum = '0;
			dec_mode = MODE_NORMAL;
		end
		default: begin
			// Normal mode: a backslash opens an escape, a newline is dropped.
			if (it.in_char == CH_BACKSLASH) begin
				if (it.in_last)
					res.status = ST_LONE;
				dec_mode = MODE_ESCAPE;
			end else if (it.in_char != CH_NEWLINE) begin
				res.out_byte = it.in_char;
				res.has_byte = 1'b1;
				emit = 1'b1;
				dec_mode = MODE_NORMAL;
			end else begin
				dec_mode = MODE_NORMAL;
			end
		end
		endcase

		// The final character always closes the string with exactly one result.
		if (it.in_last) begin
			emit = 1'b1;
			res.string_end = 1'b1;
			dec_mode = MODE_NORMAL;
			code_sum = '0;
		end
		if (emit)
			awaited_results.push_back(res);
	endtask

	task automatic check_field(input string field, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", field, want, got);
			errors++;
		end
	endtask

	// Results are checked before the same edge's character is predicted; the block's
	// latency keeps a character from producing a result at the edge it is taken.
	always @(posedge clk or negedge arst_n) begin : monitor
		out_item_t want;
		out_item_t got;
		if (!arst_n) begin
			dec_mode = MODE_NORMAL;
			code_sum = '0;
			awaited_results.delete();
			outstanding = 0;
		end else begin
			if (decoded.valid && decoded.ready) begin
				got = decoded.payload;
				if (awaited_results.size() == 0) begin
					$error("unexpected result: byte %0d, has_byte %0b, status %0d, end %0b",
						got.out_byte, got.has_byte, got.status, got.string_end);
					errors++;
				end else begin
					want = awaited_results.pop_front();
					check_field("out_byte", int'(want.out_byte), int'(got.out_byte));
					check_field("has_byte", int'(want.has_byte), int'(got.has_byte));
					check_field("status", int'(want.status), int'(got.status));
					check_field("string_end", int'(want.string_end), int'(got.string_end));
				end
				if (got.has_byte)
					bytes_seen++;
				if (got.status == ST_UNKNOWN)
					warnings_seen++;
				if (got.status == ST_LONE || got.status == ST_SHORT)
					truncations_seen++;
				if (got.string_end)
					strings_seen++;
			end
			if (text.valid && text.ready) begin
				decode_char(text.payload);
				chars_seen++;
			end
			outstanding = awaited_results.size();
		end
	end

endmodule

// ===== tb/escape_sequence_decoder_top_tb.sv =====
// Testbench top for the escape sequence decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module escape_sequence_decoder_top_tb;
	import esd_pkg::*;

	localparam int RANDOM_CHARS = 650;
	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 6;
	localparam int HOLD_CYCLES  = 300;
	localparam int HOLD_AFTER   = 150;

	logic clk;
	logic arst_n;

	esd_in_if  text_ch();
	esd_out_if dec_ch();

	int errors;
	int outstanding;
	int chars_seen;
	int strings_seen;
	int bytes_seen;
	int warnings_seen;
	int truncations_seen;

	in_item_t char_stream[$];
	string    esc_letters = "n\\beftrva";

	escape_sequence_decoder_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.text    (text_ch),
		.decoded (dec_ch)
	);

	esd_decode_check u_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.text             (text_ch),
		.decoded          (dec_ch),
		.errors           (errors),
		.outstanding      (outstanding),
		.chars_seen       (chars_seen),
		.strings_seen     (strings_seen),
		.bytes_seen       (bytes_seen),
		.warnings_seen    (warnings_seen),
		.truncations_seen (truncations_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Reset is held at the start of the run and never again.
	initial begin
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic push_char(input logic [7:0] c, input logic last);
		in_item_t it;
		it.in_char = c;
		it.in_last = last;
		char_stream.push_back(it);
	endtask

	// Queues a whole string; its final character carries the last flag.
	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i], i == s.len() - 1);
	endtask

	// Mostly a decimal digit, sometimes any character, since the digits go unchecked.
	function automatic logic [7:0] code_digit();
		if ($urandom_range(0, 3) != 0)
			return DIGIT_BASE + 8'($urandom_range(0, 9));
		return 8'($urandom_range(1, 255));
	endfunction

	// One random string built from plain characters, escapes and noise, sometimes
	// cut short inside an escape.
	task automatic add_random_string();
		logic [7:0] word[$];
		logic [7:0] c;
		logic       known;
		int         tokens;
		int         kind;
		tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
		repeat (tokens) begin
			kind = $urandom_range(0, 99);
			if (kind < 35) begin
				if ($urandom_range(0, 9) == 0) begin
					c = CH_NEWLINE;
				end else begin
					do c = 8'($urandom_range(1, 255)); while (c == CH_BACKSLASH);
				end
				word.push_back(c);
			end else if (kind < 55) begin
				word.push_back(CH_BACKSLASH);
				word.push_back(esc_letters[$urandom_range(0, esc_letters.len() - 1)]);
			end else if (kind < 75) begin
				word.push_back(CH_BACKSLASH);
				word.push_back(CH_CODE);
				repeat (3) word.push_back(code_digit());
			end else if (kind < 85) begin
				// An escape letter the decoder does not know.
				known = 1'b1;
				while (known) begin
					c = 8'($urandom_range(1, 255));
					known = (c == CH_CODE);
					for (int j = 0; j < esc_letters.len(); j++)
						if (c == esc_letters[j])
							known = 1'b1;
				end
				word.push_back(CH_BACKSLASH);
				word.push_back(c);
			end else begin
				word.push_back(8'($urandom_range(1, 255)));
			end
		end

		// Truncated endings: a lone backslash, or a code escape with too few characters.
		kind = $urandom_range(0, 99);
		if (kind < 26) begin
			word.push_back(CH_BACKSLASH);
			if (kind >= 8) begin
				word.push_back(CH_CODE);
				if (kind >= 14)
					word.push_back(code_digit());
				if (kind >= 20)
					word.push_back(code_digit());
			end
		end
		foreach (word[i])
			push_char(word[i], i == word.size() - 1);
	endtask

	// Sender: bursts of random length with random gaps, then the drain and the verdict.
	initial begin : sender
		int burst;
		int gap;
		int directed_n;
		text_ch.valid <= 1'b0;
		text_ch.payload <= '0;

		// Extremes of the character, every simple escape, a wrapping code escape,
		// an unknown escape, a dropped newline at the end, and two truncated endings.
		push_char(8'd1, 1'b0);
		push_char(8'd255, 1'b0);
		push_text("\n\\n\\\\\\b\\e\\f\\r\\t\\v\\a");
		push_text("\\c256");
		push_text("\\q\n");
		push_text("\\");
		push_text("\\c12");
		directed_n = char_stream.size();
		while (char_stream.size() < directed_n + RANDOM_CHARS)
			add_random_string();

		wait (arst_n === 1'b1);
		@(posedge clk);
		burst = $urandom_range(1, 24);
		foreach (char_stream[i]) begin
			text_ch.valid <= 1'b1;
			text_ch.payload <= char_stream[i];
			do @(posedge clk); while (!text_ch.ready);
			burst--;
			if (burst == 0) begin
				burst = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					text_ch.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		text_ch.valid <= 1'b0;

		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d characters in %0d strings; checked results held %0d bytes,",
			chars_seen, strings_seen, bytes_seen);
		$display("%0d unknown-escape warnings and %0d truncated-string errors.",
			warnings_seen, truncations_seen);
		if (errors == 0)
			$display("escape_sequence_decoder_top test passed");
		else
			$display("escape_sequence_decoder_top test failed");
		$finish;
	end

	// Receiver: stall pattern that rotates through four modes, plus one long hold-off
	// that fills the block and stalls its input.
	initial begin : receiver
		int cyc;
		int hold;
		int taken;
		logic held_once;
		cyc = 0;
		hold = 0;
		taken = 0;
		held_once = 1'b0;
		dec_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (dec_ch.valid && dec_ch.ready)
				taken++;
			cyc++;
			if (!held_once && taken >= HOLD_AFTER) begin
				held_once = 1'b1;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				dec_ch.ready <= 1'b0;
			end else begin
				case ((cyc / 40) % 4)
				0: dec_ch.ready <= 1'b1;
				1: dec_ch.ready <= 1'($urandom_range(0, 1));
				2: dec_ch.ready <= ($urandom_range(0, 3) != 0);
				default: dec_ch.ready <= (cyc % 5 != 0);
				endcase
			end
		end
	end

	// Watchdog: ends the run if no transfer happens on either channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((text_ch.valid && text_ch.ready) || (dec_ch.valid && dec_ch.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet == STALL_LIMIT) begin
				$display("escape_sequence_decoder_top test failed");
				$finish;
			end
		end
	end

endmodule
